@@ rtl/quaternion_vector_rotate_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Quaternion vector rotate unit assertion macros
// Concurrent assertion wrappers clocked on clk_i; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define QVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define QVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define QVR_ASSERT(lbl, prop, msg)
`define QVR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotate package
// Shared widths, payload types and the fixed-point round and clamp helpers.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int unsigned InW   = 16;
  localparam int unsigned QFrac = 14;
  localparam int unsigned TermW = 19;
  localparam int unsigned OutW  = 18;
  localparam int unsigned P1W   = 2 * InW;          // stage one product
  localparam int unsigned S1W   = P1W + 1;          // sum of three products
  localparam int unsigned P2W   = TermW + InW;      // stage two product
  localparam int unsigned S2W   = P2W + 2;          // sum of four products
  localparam int unsigned R2W   = S2W - QFrac;      // rounded output sum

  localparam logic signed [S1W-1:0] Half1 = S1W'(1) <<< (QFrac - 1);
  localparam logic signed [S2W-1:0] Half2 = S2W'(1) <<< (QFrac - 1);
  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  typedef struct packed {
    logic signed [InW-1:0] w;
    logic signed [InW-1:0] z;
    logic signed [InW-1:0] y;
    logic signed [InW-1:0] x;
  } quat_t;

  typedef struct packed {
    logic signed [InW-1:0] z;
    logic signed [InW-1:0] y;
    logic signed [InW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic signed [TermW-1:0] w;
    logic signed [TermW-1:0] z;
    logic signed [TermW-1:0] y;
    logic signed [TermW-1:0] x;
  } term_t;

  typedef struct packed {
    logic                   clip;
    logic signed [OutW-1:0] z;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] x;
  } result_t;

  typedef struct packed {
    logic                   clip;
    logic signed [OutW-1:0] val;
  } sat_t;

  // Add half an LSB, then floor by dropping the fraction bits.
  function automatic logic signed [TermW-1:0] round_term(input logic signed [S1W-1:0] s);
    logic signed [S1W-1:0] b;
    b = s + Half1;
    return b[S1W-1:QFrac];
  endfunction

  function automatic logic signed [R2W-1:0] round_out(input logic signed [S2W-1:0] s);
    logic signed [S2W-1:0] b;
    b = s + Half2;
    return b[S2W-1:QFrac];
  endfunction

  function automatic sat_t sat_out(input logic signed [R2W-1:0] v);
    sat_t r;
    if (v > R2W'(OutMax)) begin
      r.clip = 1'b1;
      r.val  = OutMax;
    end else if (v < R2W'(OutMin)) begin
      r.clip = 1'b1;
      r.val  = OutMin;
    end else begin
      r.clip = 1'b0;
      r.val  = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/qvr_term_stage.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotate term stage
// Forms the four intermediate terms of q * v: a product register followed by
// a sum, round and term register. The quaternion travels along.
// ----------------------------------------------------------------------------
module qvr_term_stage
  import qvr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  quat_t quat_i,
  input  vec_t  vec_i,
  output logic  valid_o,
  input  logic  ready_i,
  output quat_t quat_o,
  output term_t term_o
);

  logic                  prod_valid_q;
  logic                  term_valid_q;
  logic                  prod_en;
  logic                  term_en;
  logic signed [P1W-1:0] prod_q [12];
  quat_t                 prod_quat_q;
  quat_t                 term_quat_q;
  term_t                 term_q;
  term_t                 term_d;

  assign term_en = !term_valid_q || ready_i;
  assign prod_en = !prod_valid_q || term_en;
  assign ready_o = prod_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      term_valid_q <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_valid_q <= valid_i;
      end
      if (term_en) begin
        term_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en && valid_i) begin
      prod_q[0]   <= P1W'(quat_i.w) * P1W'(vec_i.x);
      prod_q[1]   <= P1W'(quat_i.y) * P1W'(vec_i.z);
      prod_q[2]   <= P1W'(quat_i.z) * P1W'(vec_i.y);
      prod_q[3]   <= P1W'(quat_i.w) * P1W'(vec_i.y);
      prod_q[4]   <= P1W'(quat_i.z) * P1W'(vec_i.x);
      prod_q[5]   <= P1W'(quat_i.x) * P1W'(vec_i.z);
      prod_q[6]   <= P1W'(quat_i.w) * P1W'(vec_i.z);
      prod_q[7]   <= P1W'(quat_i.x) * P1W'(vec_i.y);
      prod_q[8]   <= P1W'(quat_i.y) * P1W'(vec_i.x);
      prod_q[9]   <= P1W'(quat_i.x) * P1W'(vec_i.x);
      prod_q[10]  <= P1W'(quat_i.y) * P1W'(vec_i.y);
      prod_q[11]  <= P1W'(quat_i.z) * P1W'(vec_i.z);
      prod_quat_q <= quat_i;
    end
  end

  always_comb begin
    term_d.x = round_term(S1W'(prod_q[0]) + S1W'(prod_q[1]) - S1W'(prod_q[2]));
    term_d.y = round_term(S1W'(prod_q[3]) + S1W'(prod_q[4]) - S1W'(prod_q[5]));
    term_d.z = round_term(S1W'(prod_q[6]) + S1W'(prod_q[7]) - S1W'(prod_q[8]));
    term_d.w = round_term(S1W'(prod_q[9]) + S1W'(prod_q[10]) + S1W'(prod_q[11]));
  end

  always_ff @(posedge clk_i) begin
    if (term_en && prod_valid_q) begin
      term_q      <= term_d;
      term_quat_q <= prod_quat_q;
    end
  end

  assign valid_o = term_valid_q;
  assign quat_o  = term_quat_q;
  assign term_o  = term_q;

endmodule

@@ rtl/qvr_out_stage.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotate output stage
// Multiplies the terms back by the quaternion, then sums, rounds and clamps
// into the output register.
// ----------------------------------------------------------------------------
module qvr_out_stage
  import qvr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  quat_t   quat_i,
  input  term_t   term_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic                  prod_valid_q;
  logic                  res_valid_q;
  logic                  prod_en;
  logic                  res_en;
  logic signed [P2W-1:0] prod_q [12];
  result_t               res_q;
  result_t               res_d;
  sat_t                  sat_x;
  sat_t                  sat_y;
  sat_t                  sat_z;

  assign res_en  = !res_valid_q || ready_i;
  assign prod_en = !prod_valid_q || res_en;
  assign ready_o = prod_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_valid_q <= valid_i;
      end
      if (res_en) begin
        res_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en && valid_i) begin
      prod_q[0]  <= P2W'(term_i.w) * P2W'(quat_i.x);
      prod_q[1]  <= P2W'(term_i.x) * P2W'(quat_i.w);
      prod_q[2]  <= P2W'(term_i.y) * P2W'(quat_i.z);
      prod_q[3]  <= P2W'(term_i.z) * P2W'(quat_i.y);
      prod_q[4]  <= P2W'(term_i.w) * P2W'(quat_i.y);
      prod_q[5]  <= P2W'(term_i.y) * P2W'(quat_i.w);
      prod_q[6]  <= P2W'(term_i.z) * P2W'(quat_i.x);
      prod_q[7]  <= P2W'(term_i.x) * P2W'(quat_i.z);
      prod_q[8]  <= P2W'(term_i.w) * P2W'(quat_i.z);
      prod_q[9]  <= P2W'(term_i.z) * P2W'(quat_i.w);
      prod_q[10] <= P2W'(term_i.x) * P2W'(quat_i.y);
      prod_q[11] <= P2W'(term_i.y) * P2W'(quat_i.x);
    end
  end

  always_comb begin
    sat_x = sat_out(round_out(S2W'(prod_q[0]) + S2W'(prod_q[1])
                              - S2W'(prod_q[2]) + S2W'(prod_q[3])));
    sat_y = sat_out(round_out(S2W'(prod_q[4]) + S2W'(prod_q[5])
                              - S2W'(prod_q[6]) + S2W'(prod_q[7])));
    sat_z = sat_out(round_out(S2W'(prod_q[8]) + S2W'(prod_q[9])
                              - S2W'(prod_q[10]) + S2W'(prod_q[11])));
    res_d.x    = sat_x.val;
    res_d.y    = sat_y.val;
    res_d.z    = sat_z.val;
    res_d.clip = sat_x.clip | sat_y.clip | sat_z.clip;
  end

  always_ff @(posedge clk_i) begin
    if (res_en && prod_valid_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = res_valid_q;
  assign result_o = res_q;

endmodule

@@ rtl/quaternion_vector_rotate_unit.sv @@
// ----------------------------------------------------------------------------
// Quaternion vector rotate unit
// Rotates a 3-vector by a Q2.14 quaternion, q * v * conj(q), in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis group: one quaternion and one vector per
//   request. Results leave on the m_axis group: the rotated vector, clamped
//   to 18 bits signed, with a clip flag in tuser.
//   Four register stages: stage one products, rounded intermediate terms,
//   stage two products, and the clamped output register, which a request
//   passes through in that order once it is accepted. One request is taken
//   every cycle while the output is drained.
//   Each stage holds its item while the stage after it is full, so a stall
//   on m_axis_tready fills the bubbles first; s_axis_tready drops only once
//   all four stages hold an item. Nothing is dropped or repeated.
//   Reset clears all stage valid bits, so the pipeline starts empty and
//   s_axis_tready is high as soon as reset is released. The quaternion is
//   not normalized: a non-unit one also scales the vector by its squared norm.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotate_unit_assert.svh"

module quaternion_vector_rotate_unit
  import qvr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // quat_x [15:0], quat_y [31:16], quat_z [47:32], quat_w [63:48],
  // vec_x [79:64], vec_y [95:80], vec_z [111:96]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x [17:0], out_y [35:18], out_z [53:36], zero fill [55:54]
  output logic [55:0]  m_axis_tdata,
  // clipped [0]
  output logic         m_axis_tuser
);

  quat_t   quat_in;
  vec_t    vec_in;
  logic    mid_valid;
  logic    mid_ready;
  quat_t   mid_quat;
  term_t   mid_term;
  result_t result;

  assign quat_in.x = s_axis_tdata[15:0];
  assign quat_in.y = s_axis_tdata[31:16];
  assign quat_in.z = s_axis_tdata[47:32];
  assign quat_in.w = s_axis_tdata[63:48];
  assign vec_in.x  = s_axis_tdata[79:64];
  assign vec_in.y  = s_axis_tdata[95:80];
  assign vec_in.z  = s_axis_tdata[111:96];

  qvr_term_stage u_term_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .quat_i  (quat_in),
    .vec_i   (vec_in),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .quat_o  (mid_quat),
    .term_o  (mid_term)
  );

  qvr_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mid_valid),
    .ready_o  (mid_ready),
    .quat_i   (mid_quat),
    .term_i   (mid_term),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result)
  );

  assign m_axis_tdata = {2'b00, result.z, result.y, result.x};
  assign m_axis_tuser = result.clip;

  // A raised clip flag means at least one component sits on a bound.
  `QVR_ASSERT(a_clip_on_bound,
    m_axis_tvalid && result.clip |->
      result.x == OutMax || result.x == OutMin ||
      result.y == OutMax || result.y == OutMin ||
      result.z == OutMax || result.z == OutMin,
    "clip flag set with no component at a bound")

  // The input side only stalls when the output register holds a result.
  `QVR_ASSERT(a_stall_needs_output,
    !s_axis_tready |-> m_axis_tvalid,
    "input stalled while the output register is empty")

  // Two stage boundaries: the middle handshake cannot stall while the
  // output stage is empty.
  `QVR_ASSERT(a_mid_stall_needs_output,
    mid_valid && !mid_ready |-> m_axis_tvalid,
    "middle stall with an empty output stage")

  // The pipeline comes out of reset empty.
  `QVR_ASSERT_ALWAYS(a_empty_after_reset,
    !rst_ni |=> !m_axis_tvalid,
    "result presented right after reset")

endmodule
